FILE: sv/plen_pkg.sv
// Shared constants and types for the positional list engine.
`timescale 1ns / 1ps

package plen_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // Broadcast control to every cell of the chain
  typedef struct packed {
    logic ins_en;     // open a gap at the target and write there
    logic del_en;     // close the gap at the target
    logic rep_en;     // overwrite the target
    logic hit_load;   // capture compare result
    logic hit_shift;  // move hit flags one cell towards the head
  } cell_ctl_t;

endpackage

FILE: sv/positional_list_engine_core.sv
// Top level of the positional list engine: control, result buffering and the cell chain.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  request  | req_valid / req_stall | cmd, position, value
//  response | rsp_valid / rsp_stall | status, found_position, list_length
//
// Insert, delete and replace finish in the accepting cycle; unless the port stalls, the
// word shows on the response port from the next cycle. A new request can be taken every
// cycle while no search runs. A search holds the request side until the first match reaches
// the head, or no hit flag is left, as hit flags walk one cell per cycle towards the head.
// Reset empties the list at once. A word waiting under stall does not block the next
// request; a second finished word goes to a spare slot, and requests stall until it drains.
`timescale 1ns / 1ps

module positional_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [plen_pkg::CMD_W-1:0]          cmd,
  input  logic [plen_pkg::POS_W-1:0]          position,
  input  logic signed [plen_pkg::VAL_W-1:0]   value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [plen_pkg::STAT_W-1:0]         status,
  output logic [plen_pkg::POS_W-1:0]          found_position,
  output logic [plen_pkg::LEN_W-1:0]          list_length
);
  import plen_pkg::*;

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int WW   = ((CNTW > POS_W) ? CNTW : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found;
    logic [LEN_W-1:0]  len;
  } res_t;

  state_t            state, state_next;
  logic [CNTW-1:0]   count, count_next;
  logic [CNTW-1:0]   scan_idx;
  res_t              out_res, pend_res, res;
  logic              pend_valid;
  logic              done;
  logic              go_scan;
  logic              accept;
  logic              out_free;
  logic              any_hit;
  logic [WW-1:0]     pos_w, cnt_w;
  logic              ins_pos_ok, acc_pos_ok, full;
  logic [IDXW-1:0]   target;
  cell_ctl_t         ctl;

  logic signed [VAL_W-1:0] values     [CAPACITY];
  logic signed [VAL_W-1:0] prev_v     [CAPACITY];
  logic signed [VAL_W-1:0] next_v     [CAPACITY];
  logic [CAPACITY-1:0]     hits;
  logic [CAPACITY-1:0]     next_hits;
  logic [CAPACITY-1:0]     in_list;

  assign req_stall = (state != S_IDLE) || pend_valid;
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Position checks in a width that holds both the field and the count
  assign pos_w      = WW'(position);
  assign cnt_w      = WW'(count);
  assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
  assign acc_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign full       = (cnt_w == WW'(CAPACITY));
  assign target     = IDXW'(pos_w - WW'(1));
  assign any_hit    = |hits;

  // Decode the request or step the search, and form the finished word
  always_comb begin
    ctl        = '0;
    count_next = count;
    state_next = state;
    done       = 1'b0;
    go_scan    = 1'b0;
    res.status = ST_OK;
    res.found  = '0;
    res.len    = LEN_W'(cnt_w);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              done = 1'b1;
              if (!ins_pos_ok) begin
                res.status = ST_BADPOS;
              end else if (full) begin
                res.status = ST_FULL;
              end else begin
                ctl.ins_en = 1'b1;
                count_next = count + 1'b1;
              end
            end
            CMD_DELETE: begin
              done = 1'b1;
              if (!acc_pos_ok) begin
                res.status = ST_BADPOS;
              end else begin
                ctl.del_en = 1'b1;
                count_next = count - 1'b1;
              end
            end
            CMD_SEARCH: begin
              ctl.hit_load = 1'b1;
              go_scan      = 1'b1;
              state_next   = S_SCAN;
            end
            default: begin
              done = 1'b1;
              if (!acc_pos_ok) begin
                res.status = ST_BADPOS;
              end else begin
                ctl.rep_en = 1'b1;
              end
            end
          endcase
          res.len = LEN_W'(WW'(count_next));
        end
      end
      S_SCAN: begin
        if (hits[0]) begin
          done       = 1'b1;
          res.found  = POS_W'(WW'(scan_idx) + WW'(1));
          state_next = S_IDLE;
        end else if (!any_hit) begin
          done       = 1'b1;
          res.status = ST_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          ctl.hit_shift = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (go_scan) begin
        scan_idx <= '0;
      end else if (ctl.hit_shift) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // Response register with a spare slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (done) begin
      if (out_free) begin
        rsp_valid <= 1'b1;
      end else begin
        pend_valid <= 1'b1;
      end
    end else if (pend_valid && out_free) begin
      rsp_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (out_free) begin
        out_res <= res;
      end else begin
        pend_res <= res;
      end
    end else if (pend_valid && out_free) begin
      out_res <= pend_res;
    end
  end

  assign status         = out_res.status;
  assign found_position = out_res.found;
  assign list_length    = out_res.len;

  // Chain of cells, each wired to its neighbours; the ends see zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IDXW-1:0] SLOT = IDXW'(i);

    if (i == 0) begin : g_head
      assign prev_v[i] = '0;
    end else begin : g_mid_prev
      assign prev_v[i] = values[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_v[i]    = '0;
      assign next_hits[i] = 1'b0;
    end else begin : g_mid_next
      assign next_v[i]    = values[i+1];
      assign next_hits[i] = hits[i+1];
    end

    assign in_list[i] = (WW'(i) < cnt_w);

    plen_cell #(
      .IDXW (IDXW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .target     (target),
      .slot       (SLOT),
      .in_list    (in_list[i]),
      .wr_value   (value),
      .prev_value (prev_v[i]),
      .next_value (next_v[i]),
      .next_hit   (next_hits[i]),
      .value      (values[i]),
      .hit        (hits[i])
    );
  end

endmodule

FILE: sv/plen_cell.sv
// One cell of the list chain: holds a single entry and its search hit flag.
`timescale 1ns / 1ps

module plen_cell #(
  parameter int IDXW = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  plen_pkg::cell_ctl_t                 ctl,
  input  logic [IDXW-1:0]                     target,
  input  logic [IDXW-1:0]                     slot,
  input  logic                                in_list,
  input  logic signed [plen_pkg::VAL_W-1:0]   wr_value,
  input  logic signed [plen_pkg::VAL_W-1:0]   prev_value,
  input  logic signed [plen_pkg::VAL_W-1:0]   next_value,
  input  logic                                next_hit,
  output logic signed [plen_pkg::VAL_W-1:0]   value,
  output logic                                hit
);
  import plen_pkg::*;

  logic                    at_target;
  logic                    past_target;
  logic signed [VAL_W-1:0] value_next;

  assign at_target   = (slot == target);
  assign past_target = (slot > target);

  // Pick the new entry: hold, take a neighbour's entry, or take the written word
  always_comb begin
    value_next = value;
    if (ctl.ins_en) begin
      if (at_target) begin
        value_next = wr_value;
      end else if (past_target) begin
        value_next = prev_value;
      end
    end
    if (ctl.del_en && (at_target || past_target)) begin
      value_next = next_value;
    end
    if (ctl.rep_en && at_target) begin
      value_next = wr_value;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Hit flag: load on a search, then pass towards the head
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.hit_load) begin
      hit <= in_list && (value == wr_value);
    end else if (ctl.hit_shift) begin
      hit <= next_hit;
    end
  end

endmodule
